FILE: rtl/ftcd_pkg.sv
// ftcd_pkg: shared types, widths and constants of the force/torque contact detector
// depends on nothing; used by every other rtl file
`default_nettype none

package ftcd_pkg;

	// fixed point and field widths
	localparam int FRAC_BITS = 16;
	localparam int FORCE_W   = 32;
	localparam int GDIR_W    = 18;
	localparam int CALIB_W   = 16;
	localparam int MASS_W    = 24;
	localparam int THR_W     = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOOL_MASS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_THRESH  = 2'd2;

	// reset values of the registers
	localparam logic [CALIB_W-1:0] CALIB_RESET = 16'd100;
	localparam logic [MASS_W-1:0]  MASS_RESET  = '0;
	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(64'd1 << FRAC_BITS);

	// command codes
	localparam logic CMD_SAMPLE    = 1'b0;
	localparam logic CMD_EMERGENCY = 1'b1;

	// 9.81 in fixed point, rounded to nearest
	localparam longint GRAVITY_Q = ((longint'(981) << FRAC_BITS) + 50) / 100;
	localparam int     GRAV_W    = $clog2(GRAVITY_Q + 1);

	// weight magnitude, one spare bit for the rounding carry
	localparam int W_W = MASS_W + GRAV_W - FRAC_BITS + 1;

	// shared multiplier operands (signed)
	localparam int MUL_A_W = FORCE_W;
	localparam int MUL_B_W = W_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// compensated force, force minus bias, running-mean numerator
	localparam int F_W   = FORCE_W + 2;
	localparam int C_W   = F_W + 1;
	localparam int NUM_W = FORCE_W + CALIB_W + 2;
	localparam int DVD_W = NUM_W - 1;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

	// axis index
	localparam int AXES   = 3;
	localparam int AXIS_W = 2;
	localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WMUL,
		S_WCAP,
		S_GMUL,
		S_GCAP,
		S_DEC,
		S_CMP,
		S_BMUL,
		S_BCAP,
		S_ABS,
		S_DSTART,
		S_DWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

FILE: rtl/ftcd_sample_if.sv
// ftcd_sample_if: valid/ready channel carrying one input transaction
// depends on ftcd_pkg for field widths
`default_nettype none

interface ftcd_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic signed [ftcd_pkg::FORCE_W-1:0]  force_x;
	logic signed [ftcd_pkg::FORCE_W-1:0]  force_y;
	logic signed [ftcd_pkg::FORCE_W-1:0]  force_z;
	logic signed [ftcd_pkg::GDIR_W-1:0]   gravity_dir_x;
	logic signed [ftcd_pkg::GDIR_W-1:0]   gravity_dir_y;
	logic signed [ftcd_pkg::GDIR_W-1:0]   gravity_dir_z;
	logic                                 transform_valid;
	logic                                 emergency_value;

	modport source (
		output valid, cmd, force_x, force_y, force_z,
		output gravity_dir_x, gravity_dir_y, gravity_dir_z,
		output transform_valid, emergency_value,
		input  ready
	);

	modport sink (
		input  valid, cmd, force_x, force_y, force_z,
		input  gravity_dir_x, gravity_dir_y, gravity_dir_z,
		input  transform_valid, emergency_value,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/ftcd_result_if.sv
// ftcd_result_if: valid/ready channel carrying one result transaction
// depends on ftcd_pkg for field widths
`default_nettype none

interface ftcd_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 contact_flag;
	logic                                 calibrating;
	logic signed [ftcd_pkg::FORCE_W-1:0]  clean_force_x;
	logic signed [ftcd_pkg::FORCE_W-1:0]  clean_force_y;
	logic signed [ftcd_pkg::FORCE_W-1:0]  clean_force_z;

	modport source (
		output valid, contact_flag, calibrating,
		output clean_force_x, clean_force_y, clean_force_z,
		input  ready
	);

	modport sink (
		input  valid, contact_flag, calibrating,
		input  clean_force_x, clean_force_y, clean_force_z,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/ftcd_mul.sv
// ftcd_mul: shared signed multiplier with registered product
// depends on ftcd_pkg for operand widths
`default_nettype none

module ftcd_mul (
	input  wire logic                                clk,
	input  wire logic signed [ftcd_pkg::MUL_A_W-1:0] a,
	input  wire logic signed [ftcd_pkg::MUL_B_W-1:0] b,
	output logic signed [ftcd_pkg::PROD_W-1:0]       p_q
);

	logic signed [ftcd_pkg::PROD_W-1:0] a_ext;
	logic signed [ftcd_pkg::PROD_W-1:0] b_ext;

	assign a_ext = ftcd_pkg::PROD_W'(a);
	assign b_ext = ftcd_pkg::PROD_W'(b);

	always_ff @(posedge clk) begin
		p_q <= a_ext * b_ext;
	end

endmodule

`default_nettype wire

FILE: rtl/ftcd_div.sv
// ftcd_div: radix-2 restoring divider, one quotient bit per cycle
// depends on ftcd_pkg for widths and the status struct
`default_nettype none

module ftcd_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [ftcd_pkg::DVD_W-1:0]        dividend,
	input  wire logic [ftcd_pkg::CALIB_W-1:0]      divisor,
	output logic [ftcd_pkg::DVD_W-1:0]             quotient,
	output ftcd_pkg::div_status_t                  status
);

	logic [ftcd_pkg::CALIB_W-1:0]   rem_q;
	logic [ftcd_pkg::DVD_W-1:0]     quo_q;
	logic [ftcd_pkg::CALIB_W-1:0]   dsr_q;
	logic [ftcd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ftcd_pkg::CALIB_W:0]     trial;
	logic                           fits;

	// shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[ftcd_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ftcd_pkg::DIV_CNT_W'(ftcd_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ftcd_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? ftcd_pkg::CALIB_W'(trial - {1'b0, dsr_q})
			              : ftcd_pkg::CALIB_W'(trial);
			quo_q <= {quo_q[ftcd_pkg::DVD_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/ft_sensor_contact_detector_core.sv
// ft_sensor_contact_detector_core: top level, sequencer, state and output register
// depends on ftcd_pkg, ftcd_sample_if, ftcd_result_if, ftcd_mul, ftcd_div
`default_nettype none

// Force sensor contact detector. Each force sample (signed Q15.16) comes with the
// gravity column of the sensor rotation; the tool weight, round(tool_mass * 9.81)
// projected on that column, is added per axis. While the accepted sample count is
// below calibration_samples the sample updates a per-axis running-mean bias and is
// returned without bias removal (calibrating = 1). Afterwards the bias is subtracted
// and contact_flag is set when |clean x| exceeds force_threshold. An emergency event
// forces the flag to emergency_value and returns zero forces. A sample without a
// valid transform is dropped silently. One shared multiplier and one radix-2
// divider do all arithmetic under a sequencer, and sample.ready is high only in the
// idle state. An emergency goes straight to the done state; a detection sample runs
// the weight terms, the decision and the compare; a calibration sample runs the weight
// terms and the decision, then per axis a setup and a wait on the divider for a 49-bit
// quotient, then the result load. A result register that is still full holds the done
// state until it is taken. A finished result waits in the output register, so the
// next transaction is taken while the previous result is still pending.

module ft_sensor_contact_detector_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [ftcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ftcd_pkg::CFG_W-1:0]         cfg_data,
	ftcd_sample_if.sink                             sample,
	ftcd_result_if.source                           result
);

	// configuration registers
	logic [ftcd_pkg::CALIB_W-1:0] calib_samples_q;
	logic [ftcd_pkg::MASS_W-1:0]  tool_mass_q;
	logic [ftcd_pkg::THR_W-1:0]   force_thresh_q;

	// sequencer
	ftcd_pkg::state_t            state_q;
	ftcd_pkg::state_t            state_d;
	logic [ftcd_pkg::AXIS_W-1:0] axis_q;

	// block state
	logic signed [ftcd_pkg::FORCE_W-1:0] bias_q [ftcd_pkg::AXES];
	logic [ftcd_pkg::CALIB_W-1:0]        count_q;
	logic                                flag_q;

	// per-transaction working registers
	logic signed [ftcd_pkg::FORCE_W-1:0] force_q [ftcd_pkg::AXES];
	logic signed [ftcd_pkg::GDIR_W-1:0]  gdir_q  [ftcd_pkg::AXES];
	logic [ftcd_pkg::W_W-1:0]            w_q;
	logic signed [ftcd_pkg::F_W-1:0]     f_q     [ftcd_pkg::AXES];
	logic signed [ftcd_pkg::C_W-1:0]     c_q     [ftcd_pkg::AXES];
	logic signed [ftcd_pkg::NUM_W-1:0]   num_q;
	logic [ftcd_pkg::DVD_W-1:0]          mag_q;
	logic                                neg_q;
	logic [ftcd_pkg::CALIB_W-1:0]        dsr_q;
	logic                                calib_q;

	// output register
	logic                                out_valid_q;
	logic                                out_flag_q;
	logic                                out_calib_q;
	logic signed [ftcd_pkg::FORCE_W-1:0] out_fx_q;
	logic signed [ftcd_pkg::FORCE_W-1:0] out_fy_q;
	logic signed [ftcd_pkg::FORCE_W-1:0] out_fz_q;

	// control outputs of the sequencer
	logic                                 in_ready;
	logic                                 div_start;
	logic                                 out_load;
	logic signed [ftcd_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [ftcd_pkg::MUL_B_W-1:0]  mul_b;

	// shared units
	logic signed [ftcd_pkg::PROD_W-1:0] mul_p;
	logic [ftcd_pkg::DVD_W-1:0]         div_q;
	ftcd_pkg::div_status_t              div_st;

	// derived values
	logic                                 accept;
	logic                                 calib_now;
	logic                                 axis_last;
	logic signed [ftcd_pkg::PROD_W-1:0]   p_rnd;
	logic signed [ftcd_pkg::PROD_W-1:0]   p_term;
	logic signed [ftcd_pkg::C_W-1:0]      c_x;
	logic [ftcd_pkg::C_W-1:0]             abs_x;
	logic [ftcd_pkg::DVD_W-1:0]           dividend;
	logic signed [ftcd_pkg::FORCE_W-1:0]  bias_new;
	logic [ftcd_pkg::FORCE_W:0]           q_low;

	localparam logic [ftcd_pkg::DVD_W-1:0] Q_NEG_LIMIT =
		ftcd_pkg::DVD_W'(64'd1 << (ftcd_pkg::FORCE_W - 1));
	localparam logic [ftcd_pkg::DVD_W-1:0] Q_POS_LIMIT = Q_NEG_LIMIT - 1'b1;
	localparam logic signed [ftcd_pkg::FORCE_W-1:0] SAT_MAX =
		{1'b0, {(ftcd_pkg::FORCE_W-1){1'b1}}};
	localparam logic signed [ftcd_pkg::FORCE_W-1:0] SAT_MIN =
		{1'b1, {(ftcd_pkg::FORCE_W-1){1'b0}}};

	// saturate a force-minus-bias value to the output width
	function automatic logic signed [ftcd_pkg::FORCE_W-1:0] sat_force(
		input logic signed [ftcd_pkg::C_W-1:0] v
	);
		logic signed [ftcd_pkg::FORCE_W-1:0] r;
		if (v > ftcd_pkg::C_W'(SAT_MAX)) begin
			r = SAT_MAX;
		end else if (v < ftcd_pkg::C_W'(SAT_MIN)) begin
			r = SAT_MIN;
		end else begin
			r = ftcd_pkg::FORCE_W'(v);
		end
		return r;
	endfunction

	assign accept    = sample.valid && in_ready;
	assign calib_now = count_q < calib_samples_q;
	assign axis_last = axis_q == ftcd_pkg::AXIS_LAST;

	// round to nearest, ties up, then drop the fraction
	assign p_rnd  = mul_p + ftcd_pkg::PROD_W'(ftcd_pkg::ROUND_HALF);
	assign p_term = p_rnd >>> ftcd_pkg::FRAC_BITS;

	// |clean x| for the threshold compare
	assign c_x   = c_q[0];
	assign abs_x = c_x[ftcd_pkg::C_W-1] ? ftcd_pkg::C_W'(-c_x) : ftcd_pkg::C_W'(c_x);

	// running mean: divide with half the divisor added, ties away from zero
	assign dividend = mag_q + ftcd_pkg::DVD_W'(dsr_q >> 1);

	// signed, saturated quotient becomes the new bias
	assign q_low = div_q[ftcd_pkg::FORCE_W:0];
	always_comb begin
		if (neg_q) begin
			bias_new = (div_q > Q_NEG_LIMIT) ? SAT_MIN
			                                 : ftcd_pkg::FORCE_W'(~q_low + 1'b1);
		end else begin
			bias_new = (div_q > Q_POS_LIMIT) ? SAT_MAX
			                                 : ftcd_pkg::FORCE_W'(q_low);
		end
	end

	// shared units
	ftcd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ftcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dsr_q),
		.quotient (div_q),
		.status   (div_st)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ftcd_pkg::S_IDLE: begin
				if (sample.valid) begin
					if (sample.cmd == ftcd_pkg::CMD_EMERGENCY) begin
						state_d = ftcd_pkg::S_DONE;
					end else if (sample.transform_valid) begin
						state_d = ftcd_pkg::S_WMUL;
					end
				end
			end
			ftcd_pkg::S_WMUL:   state_d = ftcd_pkg::S_WCAP;
			ftcd_pkg::S_WCAP:   state_d = ftcd_pkg::S_GMUL;
			ftcd_pkg::S_GMUL:   state_d = ftcd_pkg::S_GCAP;
			ftcd_pkg::S_GCAP: begin
				state_d = axis_last ? ftcd_pkg::S_DEC : ftcd_pkg::S_GMUL;
			end
			ftcd_pkg::S_DEC: begin
				state_d = calib_now ? ftcd_pkg::S_BMUL : ftcd_pkg::S_CMP;
			end
			ftcd_pkg::S_CMP:    state_d = ftcd_pkg::S_DONE;
			ftcd_pkg::S_BMUL:   state_d = ftcd_pkg::S_BCAP;
			ftcd_pkg::S_BCAP:   state_d = ftcd_pkg::S_ABS;
			ftcd_pkg::S_ABS:    state_d = ftcd_pkg::S_DSTART;
			ftcd_pkg::S_DSTART: state_d = ftcd_pkg::S_DWAIT;
			ftcd_pkg::S_DWAIT: begin
				if (div_st.done) begin
					state_d = axis_last ? ftcd_pkg::S_DONE : ftcd_pkg::S_BMUL;
				end
			end
			ftcd_pkg::S_DONE: begin
				if (!out_valid_q || result.ready) begin
					state_d = ftcd_pkg::S_IDLE;
				end
			end
			default: state_d = ftcd_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: handshake, multiplier operands, divider start
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ftcd_pkg::S_IDLE: in_ready = 1'b1;
			ftcd_pkg::S_WMUL: begin
				mul_a = $signed({{(ftcd_pkg::MUL_A_W-ftcd_pkg::MASS_W){1'b0}}, tool_mass_q});
				mul_b = $signed(ftcd_pkg::MUL_B_W'(ftcd_pkg::GRAVITY_Q));
			end
			ftcd_pkg::S_GMUL: begin
				mul_a = ftcd_pkg::MUL_A_W'(gdir_q[axis_q]);
				mul_b = $signed({1'b0, w_q});
			end
			ftcd_pkg::S_BMUL: begin
				mul_a = bias_q[axis_q];
				mul_b = $signed({{(ftcd_pkg::MUL_B_W-ftcd_pkg::CALIB_W){1'b0}}, count_q});
			end
			ftcd_pkg::S_DSTART: div_start = 1'b1;
			ftcd_pkg::S_DONE:   out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	// control state and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ftcd_pkg::S_IDLE;
			axis_q          <= ftcd_pkg::AXIS_FIRST;
			calib_samples_q <= ftcd_pkg::CALIB_RESET;
			tool_mass_q     <= ftcd_pkg::MASS_RESET;
			force_thresh_q  <= ftcd_pkg::THR_RESET;
			count_q         <= '0;
			flag_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < ftcd_pkg::AXES; i++) begin
				bias_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_write) begin
				case (cfg_index)
					ftcd_pkg::REG_CALIB_SAMPLES:
						calib_samples_q <= cfg_data[ftcd_pkg::CALIB_W-1:0];
					ftcd_pkg::REG_TOOL_MASS:
						tool_mass_q <= cfg_data[ftcd_pkg::MASS_W-1:0];
					ftcd_pkg::REG_FORCE_THRESH:
						force_thresh_q <= cfg_data[ftcd_pkg::THR_W-1:0];
					default: ;
				endcase
			end

			// axis walk for the weight terms and the per-axis divisions
			case (state_q)
				ftcd_pkg::S_IDLE, ftcd_pkg::S_DEC: axis_q <= ftcd_pkg::AXIS_FIRST;
				ftcd_pkg::S_GCAP: begin
					if (!axis_last) axis_q <= axis_q + 1'b1;
				end
				ftcd_pkg::S_DWAIT: begin
					if (div_st.done && !axis_last) axis_q <= axis_q + 1'b1;
				end
				default: ;
			endcase

			// emergency transaction forces the flag
			if (accept && sample.cmd == ftcd_pkg::CMD_EMERGENCY) begin
				flag_q <= sample.emergency_value;
			end

			if (state_q == ftcd_pkg::S_CMP) begin
				flag_q <= abs_x > ftcd_pkg::C_W'(force_thresh_q);
			end

			if (state_q == ftcd_pkg::S_DWAIT && div_st.done) begin
				bias_q[axis_q] <= bias_new;
				if (axis_last) count_q <= count_q + 1'b1;
			end

			// output register: a result leaves on its handshake, a new one loads
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			force_q[0] <= sample.force_x;
			force_q[1] <= sample.force_y;
			force_q[2] <= sample.force_z;
			gdir_q[0]  <= sample.gravity_dir_x;
			gdir_q[1]  <= sample.gravity_dir_y;
			gdir_q[2]  <= sample.gravity_dir_z;
			// an emergency result carries zero forces
			calib_q    <= calib_now;
			for (int i = 0; i < ftcd_pkg::AXES; i++) begin
				c_q[i] <= '0;
			end
		end

		case (state_q)
			ftcd_pkg::S_WCAP: begin
				w_q <= ftcd_pkg::W_W'(p_term);
			end
			ftcd_pkg::S_GCAP: begin
				f_q[axis_q] <= ftcd_pkg::F_W'(force_q[axis_q]) + ftcd_pkg::F_W'(p_term);
			end
			ftcd_pkg::S_DEC: begin
				calib_q <= calib_now;
				dsr_q   <= count_q + 1'b1;
				for (int i = 0; i < ftcd_pkg::AXES; i++) begin
					if (calib_now) begin
						c_q[i] <= ftcd_pkg::C_W'(f_q[i]);
					end else begin
						c_q[i] <= ftcd_pkg::C_W'(f_q[i]) - ftcd_pkg::C_W'(bias_q[i]);
					end
				end
			end
			ftcd_pkg::S_BCAP: begin
				num_q <= ftcd_pkg::NUM_W'(mul_p) + ftcd_pkg::NUM_W'(f_q[axis_q]);
			end
			ftcd_pkg::S_ABS: begin
				neg_q <= num_q[ftcd_pkg::NUM_W-1];
				mag_q <= num_q[ftcd_pkg::NUM_W-1] ? ftcd_pkg::DVD_W'(-num_q)
				                                  : ftcd_pkg::DVD_W'(num_q);
			end
			default: ;
		endcase

		if (out_load) begin
			out_flag_q  <= flag_q;
			out_calib_q <= calib_q;
			out_fx_q    <= sat_force(c_q[0]);
			out_fy_q    <= sat_force(c_q[1]);
			out_fz_q    <= sat_force(c_q[2]);
		end
	end

	assign sample.ready         = in_ready;
	assign result.valid         = out_valid_q;
	assign result.contact_flag  = out_flag_q;
	assign result.calibrating   = out_calib_q;
	assign result.clean_force_x = out_fx_q;
	assign result.clean_force_y = out_fy_q;
	assign result.clean_force_z = out_fz_q;

`ifndef SYNTH
	// the divider only runs while the sequencer waits for it
	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> state_q == ftcd_pkg::S_DWAIT)
		else $error("divider busy outside the wait state");

	// a quotient is only produced for a started division
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ftcd_pkg::S_DWAIT && $past(div_st.busy))
		else $error("divider done without a running division");

	// the sample count only advances while calibration is still open
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ftcd_pkg::S_DWAIT && div_st.done && axis_last)
			|-> count_q < calib_samples_q)
		else $error("calibration sample counted past the limit");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ftcd_pkg::S_DONE && out_valid_q && !result.ready)
			|=> state_q == ftcd_pkg::S_DONE && out_valid_q)
		else $error("result register overwritten while pending");
`endif

endmodule

`default_nettype wire
